/* hdl/ecu_pkg.sv */
// ecu_pkg: shared types and constants for the epidemic cell update block
// grid geometry, cell codes, action codes, sequencer states and step struct
// no dependencies

package ecu_pkg;

    // grid geometry: a square torus of GRID_SIZE x GRID_SIZE cells, GRID_SIZE = 2**COORD_W
    localparam int COORD_W   = 6;
    localparam int GRID_SIZE = 2 ** COORD_W;
    localparam int ADDR_W    = 2 * COORD_W;
    localparam int GRID_CELLS = GRID_SIZE * GRID_SIZE;

    // word field widths
    localparam int CELL_W   = 2;
    localparam int DRAW_W   = 7;
    localparam int CHANCE_W = 7;

    // thresholds, one per infected neighbour count 1..8
    localparam int NBR_N     = 8;
    localparam int CFG_IDX_W = $clog2(NBR_N);
    localparam int CNT_W     = $clog2(NBR_N + 1);
    localparam int STEP_W    = $clog2(NBR_N + 1);

    // action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // cell state codes
    typedef enum logic [CELL_W-1:0] {
        CELL_SUSCEPTIBLE = 2'd0,
        CELL_EXPOSED     = 2'd1,
        CELL_INFECTED    = 2'd2,
        CELL_OTHER       = 2'd3
    } t_cell;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LAST,
        ST_FINISH
    } t_state;

    // per-cycle control from the sequencer to the evaluator
    typedef struct packed {
        logic start;      // a word was accepted this cycle
        logic load;       // accepted word is a load
        logic rd_vld;     // grid read data is valid this cycle
        logic rd_center;  // read data belongs to the addressed cell
        logic finish;     // result goes to the output register
    } t_step;

endpackage

/* hdl/ecu_if.sv */
// ecu_if: valid/ready channel interfaces for input, result and configuration words
// depends on ecu_pkg for field widths

// input word channel
interface ecu_in_if;
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic [ecu_pkg::COORD_W-1:0]   row;
    logic [ecu_pkg::COORD_W-1:0]   col;
    logic [ecu_pkg::CELL_W-1:0]    cell_state;
    logic [ecu_pkg::DRAW_W-1:0]    random_draw;

    modport source (output valid, action, row, col, cell_state, random_draw, input ready);
    modport sink   (input valid, action, row, col, cell_state, random_draw, output ready);
endinterface

// result word channel
interface ecu_out_if;
    logic                          valid;
    logic                          ready;
    logic [ecu_pkg::CELL_W-1:0]    next_state;

    modport source (output valid, next_state, input ready);
    modport sink   (input valid, next_state, output ready);
endinterface

// configuration write channel
interface ecu_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ecu_pkg::CFG_IDX_W-1:0] index;
    logic [ecu_pkg::CHANCE_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/ecu_ram.sv */
// ecu_ram: generic single-port synchronous ram, registered read
// no dependencies

module ecu_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ecu_seq.sv */
// ecu_seq: sequencer that accepts input words and walks the grid ram
// issues the write of a load or the nine reads of a compute; uses ecu_pkg, ecu_if

module ecu_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ecu_in_if.sink                      i_in,
    input  logic                        i_out_free,
    output ecu_pkg::t_step              o_step,
    output logic                        o_ram_we,
    output logic [ecu_pkg::ADDR_W-1:0]  o_ram_addr,
    output logic [ecu_pkg::CELL_W-1:0]  o_ram_wdata
);

    ecu_pkg::t_state               r_state, n_state;
    logic [ecu_pkg::STEP_W-1:0]    r_k, n_k;
    logic                          r_rd_vld, n_rd_vld;
    logic                          r_rd_center, n_rd_center;
    logic [ecu_pkg::COORD_W-1:0]   r_row, r_col;
    logic [ecu_pkg::COORD_W-1:0]   up, down, left, right;
    logic [ecu_pkg::COORD_W-1:0]   nbr_row, nbr_col;
    logic                          accept;

    localparam logic [ecu_pkg::COORD_W-1:0] COORD_MAX = ecu_pkg::COORD_W'(ecu_pkg::GRID_SIZE - 1);
    localparam logic [ecu_pkg::STEP_W-1:0]  K_LAST    = ecu_pkg::STEP_W'(ecu_pkg::NBR_N);
    localparam logic [ecu_pkg::STEP_W-1:0]  STEP_W_ONE = ecu_pkg::STEP_W'(1);

    assign accept = i_in.valid && i_in.ready;

    // wrapped neighbour coordinates
    assign up    = (r_row == '0) ? COORD_MAX : r_row - 1'b1;
    assign down  = (r_row == COORD_MAX) ? '0 : r_row + 1'b1;
    assign left  = (r_col == '0) ? COORD_MAX : r_col - 1'b1;
    assign right = (r_col == COORD_MAX) ? '0 : r_col + 1'b1;

    // neighbour k of eight, row-major around the cell
    always_comb begin
        case (r_k)
            4'd1:    begin nbr_row = up;    nbr_col = left;  end
            4'd2:    begin nbr_row = up;    nbr_col = r_col; end
            4'd3:    begin nbr_row = up;    nbr_col = right; end
            4'd4:    begin nbr_row = r_row; nbr_col = left;  end
            4'd5:    begin nbr_row = r_row; nbr_col = right; end
            4'd6:    begin nbr_row = down;  nbr_col = left;  end
            4'd7:    begin nbr_row = down;  nbr_col = r_col; end
            default: begin nbr_row = down;  nbr_col = right; end
        endcase
    end

    // next state and ram control
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_rd_vld    = 1'b0;
        n_rd_center = 1'b0;
        i_in.ready  = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_addr  = {nbr_row, nbr_col};
        o_ram_wdata = i_in.cell_state;
        o_step      = '0;
        o_step.rd_vld    = r_rd_vld;
        o_step.rd_center = r_rd_center;
        unique case (r_state)
            ecu_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                o_ram_addr = {i_in.row, i_in.col};
                if (i_in.valid) begin
                    o_step.start = 1'b1;
                    if (i_in.action == ecu_pkg::ACT_LOAD) begin
                        o_step.load = 1'b1;
                        o_ram_we    = 1'b1;
                        n_state     = ecu_pkg::ST_FINISH;
                    end else begin
                        n_rd_vld    = 1'b1;
                        n_rd_center = 1'b1;
                        n_k         = STEP_W_ONE;
                        n_state     = ecu_pkg::ST_READ;
                    end
                end
            end
            ecu_pkg::ST_READ: begin
                n_rd_vld = 1'b1;
                n_k      = r_k + 1'b1;
                if (r_k == K_LAST) begin
                    n_state = ecu_pkg::ST_LAST;
                end
            end
            ecu_pkg::ST_LAST: begin
                n_state = ecu_pkg::ST_FINISH;
            end
            ecu_pkg::ST_FINISH: begin
                if (i_out_free) begin
                    o_step.finish = 1'b1;
                    n_state       = ecu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ecu_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ecu_pkg::ST_IDLE;
            r_k         <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_center <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_rd_vld    <= n_rd_vld;
            r_rd_center <= n_rd_center;
        end
    end

    // addressed cell
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row <= i_in.row;
            r_col <= i_in.col;
        end
    end

endmodule

/* hdl/ecu_eval.sv */
// ecu_eval: threshold registers, neighbour count and result register
// consumes grid read data under sequencer control; uses ecu_pkg, ecu_if

module ecu_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ecu_pkg::t_step              i_step,
    input  logic [ecu_pkg::CELL_W-1:0]  i_cell_state,
    input  logic [ecu_pkg::DRAW_W-1:0]  i_random_draw,
    input  logic [ecu_pkg::CELL_W-1:0]  i_rdata,
    ecu_cfg_if.sink                     i_cfg,
    ecu_out_if.source                   o_out,
    output logic                        o_out_free
);

    logic [ecu_pkg::CHANCE_W-1:0] r_chance [ecu_pkg::NBR_N];
    logic                         r_is_load;
    logic [ecu_pkg::CELL_W-1:0]   r_load_state;
    logic [ecu_pkg::DRAW_W-1:0]   r_draw;
    logic [ecu_pkg::CELL_W-1:0]   r_center;
    logic [ecu_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_out_valid;
    logic [ecu_pkg::CELL_W-1:0]   r_out_state;
    logic [ecu_pkg::CNT_W-1:0]    cnt_m1;
    logic [ecu_pkg::CHANCE_W-1:0] chance_sel;
    logic [ecu_pkg::CELL_W-1:0]   result;

    // threshold registers, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ecu_pkg::NBR_N; i++) begin
                r_chance[i] <= '0;
            end
        end else if (i_cfg.valid) begin
            r_chance[i_cfg.index] <= i_cfg.data;
        end
    end

    // per-word context and neighbour count
    always_ff @(posedge i_clk) begin
        if (i_step.start) begin
            r_is_load    <= i_step.load;
            r_load_state <= i_cell_state;
            r_draw       <= i_random_draw;
            r_cnt        <= '0;
        end else if (i_step.rd_vld) begin
            if (i_step.rd_center) begin
                r_center <= i_rdata;
            end else if (i_rdata == ecu_pkg::CELL_INFECTED) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // threshold for the current count and the decision
    assign cnt_m1     = r_cnt - 1'b1;
    assign chance_sel = r_chance[cnt_m1[ecu_pkg::CFG_IDX_W-1:0]];

    always_comb begin
        priority if (r_is_load) begin
            result = r_load_state;
        end else if (r_center == ecu_pkg::CELL_SUSCEPTIBLE && r_cnt != '0
                     && r_draw < chance_sel) begin
            result = ecu_pkg::CELL_EXPOSED;
        end else begin
            result = r_center;
        end
    end

    // output register
    assign o_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_step.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.finish) begin
            r_out_state <= result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.next_state = r_out_state;

endmodule

/* hdl/epidemic_automaton_cell_update_top.sv */
// epidemic_automaton_cell_update_top: top level of the epidemic cell update block
// instantiates ecu_seq, ecu_ram and ecu_eval; uses ecu_pkg, ecu_if
//
//   channel  direction  carries                                     accepted when
//   i_in     in         action, row, col, cell_state, random_draw   valid && ready
//   o_out    out        next_state                                  valid && ready
//   i_cfg    in         index, data (threshold writes)              valid && ready
//
// a load word writes the grid ram and moves to the final state; a compute word reads the
// addressed cell and its eight neighbours, nine reads of the single-port grid ram, one
// per cycle, then passes ST_LAST for the last read data and steps to the output register.
// synchronous active-low reset clears the sequencer, thresholds and output valid;
// grid contents are not cleared. a full output register holds the sequencer in its
// final state; a new word is accepted while the previous result waits to be taken.

module epidemic_automaton_cell_update_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ecu_in_if.sink     i_in,
    ecu_out_if.source  o_out,
    ecu_cfg_if.sink    i_cfg
);

    ecu_pkg::t_step              step;
    logic                        out_free;
    logic                        ram_we;
    logic [ecu_pkg::ADDR_W-1:0]  ram_addr;
    logic [ecu_pkg::CELL_W-1:0]  ram_wdata;
    logic [ecu_pkg::CELL_W-1:0]  ram_rdata;

    // sequencer
    ecu_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_free  (out_free),
        .o_step      (step),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata)
    );

    // grid store
    ecu_ram #(
        .WIDTH (ecu_pkg::CELL_W),
        .DEPTH (ecu_pkg::GRID_CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // evaluator and result register
    ecu_eval u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_cell_state  (i_in.cell_state),
        .i_random_draw (i_in.random_draw),
        .i_rdata       (ram_rdata),
        .i_cfg         (i_cfg),
        .o_out         (o_out),
        .o_out_free    (out_free)
    );

endmodule
